@@ src/xlsu_pkg.sv @@
// Shared types and codes for the x86 logic and shift unit.
package xlsu_pkg;

  localparam int DataW = 32;
  localparam int OpW   = 4;
  localparam int SizeW = 2;
  localparam int CondW = 4;

  // Operation codes.
  localparam logic [OpW-1:0] OP_TEST  = 4'd0;
  localparam logic [OpW-1:0] OP_AND   = 4'd1;
  localparam logic [OpW-1:0] OP_XOR   = 4'd2;
  localparam logic [OpW-1:0] OP_OR    = 4'd3;
  localparam logic [OpW-1:0] OP_SAR   = 4'd4;
  localparam logic [OpW-1:0] OP_SHL   = 4'd5;
  localparam logic [OpW-1:0] OP_SHR   = 4'd6;
  localparam logic [OpW-1:0] OP_SETCC = 4'd7;
  localparam logic [OpW-1:0] OP_NOT   = 4'd8;
  localparam logic [OpW-1:0] OP_ROL   = 4'd9;

  // Operand size codes; any other code acts as dword.
  localparam logic [SizeW-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SizeW-1:0] SIZE_WORD = 2'd1;

  // Condition groups, taken from the upper three bits of the condition code.
  localparam logic [2:0] CC_O  = 3'd0;
  localparam logic [2:0] CC_B  = 3'd1;
  localparam logic [2:0] CC_Z  = 3'd2;
  localparam logic [2:0] CC_BE = 3'd3;
  localparam logic [2:0] CC_S  = 3'd4;
  localparam logic [2:0] CC_P  = 3'd5;
  localparam logic [2:0] CC_L  = 3'd6;
  localparam logic [2:0] CC_LE = 3'd7;

  typedef struct packed {
    logic zf;
    logic sf;
    logic cf;
    logic of;
  } flags_t;

  typedef struct packed {
    logic [CondW-1:0] cond_code;
    logic [SizeW-1:0] width_code;
    logic [DataW-1:0] src_value;
    logic [DataW-1:0] dest_value;
    logic [OpW-1:0]   req_type;
  } req_t;

  typedef struct packed {
    flags_t           flags;
    logic             write_back;
    logic [DataW-1:0] result_value;
  } rsp_t;

endpackage

@@ src/xlsu_cond.sv @@
// Evaluates an x86 condition code against the stored status flags.
module xlsu_cond (
  input  xlsu_pkg::flags_t               flags,
  input  logic [xlsu_pkg::CondW-1:0]     cond_code,
  output logic                           taken
);
  import xlsu_pkg::*;

  logic base;
  logic valid_cond;

  always_comb begin
    valid_cond = 1'b1;
    case (cond_code[3:1])
      CC_O:    base = flags.of;
      CC_B:    base = flags.cf;
      CC_Z:    base = flags.zf;
      CC_BE:   base = flags.cf | flags.zf;
      CC_S:    base = flags.sf;
      CC_L:    base = flags.sf ^ flags.of;
      CC_LE:   base = flags.zf | (flags.sf ^ flags.of);
      CC_P: begin
        // Parity is not tracked, so both parity conditions read as false.
        base       = 1'b0;
        valid_cond = 1'b0;
      end
      default: base = 1'b0;
    endcase
    taken = valid_cond & (base ^ cond_code[0]);
  end

endmodule

@@ src/xlsu_exec.sv @@
// Combinational datapath: computes one operation and the flags it leaves.
module xlsu_exec (
  input  xlsu_pkg::req_t   req,
  input  xlsu_pkg::flags_t flags_in,
  output xlsu_pkg::rsp_t   rsp
);
  import xlsu_pkg::*;

  logic [DataW-1:0]        mask;
  logic [DataW-1:0]        d;
  logic [4:0]              cnt;
  logic [DataW-1:0]        sext;
  logic [DataW-1:0]        sar_res;
  logic [DataW-1:0]        rep;
  logic [2*DataW-1:0]      rot_dbl;
  logic [DataW-1:0]        res;
  logic [DataW-1:0]        res_val;
  logic                    wb;
  logic                    sign_bit;
  logic                    cond_taken;
  flags_t                  zs_flags;
  flags_t                  logic_fl;
  flags_t                  flags_out;

  xlsu_cond u_cond (
    .flags     (flags_in),
    .cond_code (req.cond_code),
    .taken     (cond_taken)
  );

  always_comb begin
    case (req.width_code)
      SIZE_BYTE: mask = 32'h0000_00ff;
      SIZE_WORD: mask = 32'h0000_ffff;
      default:   mask = 32'hffff_ffff;
    endcase
  end

  assign d   = req.dest_value & mask;
  assign cnt = req.src_value[4:0];

  // Sign-extend from the operand width, then shift arithmetically.
  // The pattern is replicated so that a 32-bit rotate acts as a rotate at the
  // operand width with the count taken modulo that width.
  always_comb begin
    case (req.width_code)
      SIZE_BYTE: begin
        sext = {{24{d[7]}}, d[7:0]};
        rep  = {4{d[7:0]}};
      end
      SIZE_WORD: begin
        sext = {{16{d[15]}}, d[15:0]};
        rep  = {2{d[15:0]}};
      end
      default: begin
        sext = d;
        rep  = d;
      end
    endcase
  end

  assign sar_res = DataW'($signed(sext) >>> cnt);
  assign rot_dbl = {rep, rep} << cnt;

  always_comb begin
    wb = 1'b1;
    case (req.req_type)
      OP_TEST: begin
        res = d & req.src_value;
        wb  = 1'b0;
      end
      OP_AND:   res = d & req.src_value;
      OP_XOR:   res = d ^ req.src_value;
      OP_OR:    res = d | req.src_value;
      OP_SAR:   res = sar_res;
      OP_SHL:   res = d << cnt;
      OP_SHR:   res = d >> cnt;
      OP_SETCC: res = {{(DataW-1){1'b0}}, cond_taken};
      OP_NOT:   res = ~d;
      OP_ROL:   res = rot_dbl[2*DataW-1:DataW];
      default: begin
        res = '0;
        wb  = 1'b0;
      end
    endcase
    // Setcc returns 0 or 1, so masking leaves it untouched.
    res_val = res & mask;
  end

  always_comb begin
    case (req.width_code)
      SIZE_BYTE: sign_bit = res_val[7];
      SIZE_WORD: sign_bit = res_val[15];
      default:   sign_bit = res_val[31];
    endcase
  end

  always_comb begin
    zs_flags    = flags_in;
    zs_flags.zf = (res_val == '0);
    zs_flags.sf = sign_bit;
    logic_fl    = zs_flags;
    logic_fl.cf = 1'b0;
    logic_fl.of = 1'b0;
    case (req.req_type)
      OP_TEST, OP_AND, OP_XOR, OP_OR:   flags_out = logic_fl;
      OP_SAR, OP_SHL, OP_SHR, OP_ROL:   flags_out = zs_flags;
      default:                          flags_out = flags_in;
    endcase
  end

  assign rsp = {flags_out, wb, res_val};

endmodule

@@ src/x86_logic_shift_unit_with_flags.sv @@
// Top level of the x86 logic and shift unit with its status-flag register.
//
//  Channel  Dir  Bits  Contents
//  s_axis   in   80    req_type, dest_value, src_value, width_code, cond_code
//  m_axis   out  40    result_value, write_back, ZF, SF, CF, OF
//
// Each beat is captured in an input register, computed by combinational logic
// and held in the result register.
// One beat is accepted every cycle while the result side keeps up.
// The flag register is updated as a beat moves into the result register, so
// every beat sees the flags that the beat before it left.
// Reset clears both valid bits and the flags. A stalled result holds the
// result register and, once the input register is also full, s_axis_tready.
module x86_logic_shift_unit_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] req_type, [35:4] dest_value, [67:36] src_value,
  // [69:68] width_code, [73:70] cond_code, [79:74] zero
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] result_value, [32] write_back, [33] zero_flag, [34] sign_flag,
  // [35] carry_flag, [36] overflow_flag, [39:37] zero
  output logic [39:0] m_axis_tdata
);
  import xlsu_pkg::*;

  logic   in_valid;
  req_t   in_req;
  logic   out_valid;
  rsp_t   out_rsp;
  flags_t flags;
  rsp_t   exec_rsp;
  logic   advance;

  assign advance       = in_valid & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~in_valid | advance;

  xlsu_exec u_exec (
    .req      (in_req),
    .flags_in (flags),
    .rsp      (exec_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req <= s_axis_tdata[$bits(req_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flags     <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        flags     <= exec_rsp.flags;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= exec_rsp;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_rsp.flags.of, out_rsp.flags.cf, out_rsp.flags.sf,
                          out_rsp.flags.zf, out_rsp.write_back, out_rsp.result_value};

endmodule
